// File: hdl/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package hpt_pkg;

  // Coordinate format: signed, half of the bits are fraction
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned FracBits    = CoordWidth / 2;
  // Default coefficient width (signed, four integer bits)
  localparam int unsigned CoefWidthDef = 16;
  // Dot product accumulator, wraps in two's complement
  localparam int unsigned AccWidth    = 64;
  // Matrix rows: four 16-bit slots per 64-bit register
  localparam int unsigned RowWidth    = 64;
  localparam int unsigned SlotWidth   = 16;
  localparam int unsigned NumRows     = 4;
  localparam int unsigned AddrWidth   = 5;

  typedef enum logic [1:0] {
    RegRow0 = 2'd0,
    RegRow1 = 2'd1,
    RegRow2 = 2'd2,
    RegRow3 = 2'd3
  } reg_idx_e;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [RowWidth-1:0]          row_t;
  typedef logic [AccWidth-1:0]          acc_t;

  typedef struct packed {
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   w_zero;
    logic   clipped;
  } out_item_t;

endpackage

// File: hdl/hpt_dot.sv
// One matrix row dotted with (x, y, z, 1): a multiply stage and a sum stage.
// Depends on hpt_pkg for the item type and widths.
`timescale 1ns / 1ps

module hpt_dot #(
  parameter int unsigned CoefWidth = hpt_pkg::CoefWidthDef
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  hpt_pkg::row_t    row_i,
  input  hpt_pkg::in_item_t pt_i,
  output hpt_pkg::acc_t    acc_o
);

  localparam int unsigned CW = hpt_pkg::CoordWidth;
  localparam int unsigned PW = CW + CoefWidth;
  localparam int unsigned AW = hpt_pkg::AccWidth;

  logic signed [CoefWidth-1:0] coef [hpt_pkg::NumRows];
  hpt_pkg::coord_t             crd  [3];
  logic signed [PW-1:0]        prod_d [3];
  logic signed [PW-1:0]        prod_q [3];
  logic signed [AW-1:0]        wterm_d, wterm_q;
  logic signed [AW-1:0]        acc_d, acc_q;

  // Split the row into signed coefficients and form the products
  always_comb begin
    for (int j = 0; j < hpt_pkg::NumRows; j++) begin
      coef[j] = row_i[j*hpt_pkg::SlotWidth +: CoefWidth];
    end
    crd[0] = pt_i.in_x;
    crd[1] = pt_i.in_y;
    crd[2] = pt_i.in_z;
    for (int j = 0; j < 3; j++) begin
      prod_d[j] = coef[j] * crd[j];
    end
    // w = 1 in coordinate format: the last coefficient shifted up
    wterm_d = AW'(coef[3]) <<< hpt_pkg::FracBits;
  end

  // Sum the four terms, sign-extended, wrapping at the accumulator width
  assign acc_d = AW'(prod_q[0]) + AW'(prod_q[1]) + AW'(prod_q[2]) + wterm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      wterm_q <= wterm_d;
      acc_q   <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: hdl/hpt_div.sv
// Pipelined signed fractional divider with saturation, one quotient bit
// per stage. Depends on hpt_pkg for widths.
`timescale 1ns / 1ps

module hpt_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  hpt_pkg::acc_t   num_i,
  input  hpt_pkg::acc_t   den_i,
  output hpt_pkg::coord_t quo_o,
  output logic            clip_o
);

  localparam int unsigned CW = hpt_pkg::CoordWidth;
  localparam int unsigned F  = hpt_pkg::FracBits;
  localparam int unsigned H  = CW - F;
  localparam int unsigned AW = hpt_pkg::AccWidth;

  typedef struct packed {
    logic [AW-1:0] rem;
    logic [CW-1:0] low;
    logic [CW-1:0] quo;
  } div_st_t;

  logic [AW-1:0] na_q, da_q;
  logic          neg_a_q;

  div_st_t       st_d  [CW+1];
  div_st_t       st_q  [CW+1];
  logic [AW-1:0] d_d   [CW+1];
  logic [AW-1:0] d_q   [CW+1];
  logic          neg_d [CW+1];
  logic          neg_q [CW+1];
  logic          ovf_d [CW+1];
  logic          ovf_q [CW+1];

  logic [AW:0]   trial [CW];
  logic [AW:0]   diff  [CW];
  logic          ge    [CW];

  logic [CW-1:0] qf;
  logic          over, clip;
  logic [CW-1:0] res_d, res_q;
  logic          clip_q;

  // Take magnitudes and the quotient sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q    <= num_i[AW-1] ? (AW'(0) - num_i) : num_i;
      da_q    <= den_i[AW-1] ? (AW'(0) - den_i) : den_i;
      neg_a_q <= num_i[AW-1] ^ den_i[AW-1];
    end
  end

  // Load the partial remainder and flag a quotient beyond the coordinate width
  always_comb begin
    st_d[0].rem = na_q >> H;
    st_d[0].low = {na_q[H-1:0], {F{1'b0}}};
    st_d[0].quo = '0;
    d_d[0]      = da_q;
    neg_d[0]    = neg_a_q;
    ovf_d[0]    = (na_q >> H) >= da_q;
    // One restoring step per stage
    for (int k = 0; k < CW; k++) begin
      trial[k]      = {st_q[k].rem, st_q[k].low[CW-1]};
      diff[k]       = trial[k] - {1'b0, d_q[k]};
      ge[k]         = trial[k] >= {1'b0, d_q[k]};
      st_d[k+1].rem = ge[k] ? diff[k][AW-1:0] : trial[k][AW-1:0];
      st_d[k+1].low = st_q[k].low << 1;
      st_d[k+1].quo = {st_q[k].quo[CW-2:0], ge[k]};
      d_d[k+1]      = d_q[k];
      neg_d[k+1]    = neg_q[k];
      ovf_d[k+1]    = ovf_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= CW; k++) begin
        st_q[k]  <= st_d[k];
        d_q[k]   <= d_d[k];
        neg_q[k] <= neg_d[k];
        ovf_q[k] <= ovf_d[k];
      end
    end
  end

  // Apply the sign and saturate to the coordinate range
  always_comb begin
    qf   = st_q[CW].quo;
    over = ovf_q[CW] | (qf[CW-1] & (|qf[CW-2:0]));
    clip = over | (qf[CW-1] & ~neg_q[CW]);
    if (clip) begin
      res_d = neg_q[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      res_d = neg_q[CW] ? (CW'(0) - qf) : qf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      clip_q <= clip;
    end
  end

  assign quo_o  = res_q;
  assign clip_o = clip_q;

endmodule

// File: hdl/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform with perspective divide, top level.
// Pipeline: two dot product stages, then a divider of one quotient bit per stage
// plus sign, load and saturate stages.
// Throughput: one item per cycle; a stall at the output holds every stage.
// Reset clears all valid bits and loads the identity matrix.
// Depends on hpt_pkg, hpt_dot and hpt_div.
`timescale 1ns / 1ps

module homogeneous_point_transform #(
  parameter int unsigned CoefWidth = hpt_pkg::CoefWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Point stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hpt_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output hpt_pkg::out_item_t              out_data_o,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hpt_pkg::AddrWidth-1:0]   paddr,
  input  logic [hpt_pkg::RowWidth-1:0]    pwdata,
  output logic [hpt_pkg::RowWidth-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned CW     = hpt_pkg::CoordWidth;
  localparam int unsigned DivLat = CW + 3;
  localparam int unsigned Lat    = DivLat + 2;
  localparam int unsigned KFrac  = CoefWidth - 4;

  hpt_pkg::row_t     row_q [hpt_pkg::NumRows];
  hpt_pkg::reg_idx_e reg_idx;
  hpt_pkg::acc_t     acc   [hpt_pkg::NumRows];
  hpt_pkg::coord_t   quo   [3];
  logic              clip  [3];

  logic [Lat-1:0]    vld_q;
  logic [DivLat-1:0] wz_q;
  logic              en;

  // Register file: write on the access phase, read back the addressed row
  assign reg_idx = hpt_pkg::reg_idx_e'(paddr[4:3]);
  assign pready  = 1'b1;
  assign prdata  = row_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[hpt_pkg::RegRow0] <= hpt_pkg::RowWidth'(1) << KFrac;
      row_q[hpt_pkg::RegRow1] <= hpt_pkg::RowWidth'(1) << (hpt_pkg::SlotWidth + KFrac);
      row_q[hpt_pkg::RegRow2] <= hpt_pkg::RowWidth'(1) << (2*hpt_pkg::SlotWidth + KFrac);
      row_q[hpt_pkg::RegRow3] <= hpt_pkg::RowWidth'(1) << (3*hpt_pkg::SlotWidth + KFrac);
    end else if (psel && penable && pwrite) begin
      row_q[reg_idx] <= pwdata;
    end
  end

  // Advance the whole pipe unless a finished item waits at the output
  assign en         = ~vld_q[Lat-1] | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // Dot products for x, y, z and w
  for (genvar r = 0; r < hpt_pkg::NumRows; r++) begin : g_row
    hpt_dot #(
      .CoefWidth(CoefWidth)
    ) u_dot (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (row_q[r]),
      .pt_i  (in_data_i),
      .acc_o (acc[r])
    );
  end

  // Divide each coordinate by w
  for (genvar c = 0; c < 3; c++) begin : g_lane
    hpt_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (acc[c]),
      .den_i  (acc[3]),
      .quo_o  (quo[c]),
      .clip_o (clip[c])
    );
  end

  // Carry the zero-w flag alongside the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      wz_q <= {wz_q[DivLat-2:0], (acc[3] == '0)};
    end
  end

  // Zero w overrides the quotients
  always_comb begin
    out_valid_o = vld_q[Lat-1];
    if (wz_q[DivLat-1]) begin
      out_data_o.out_x   = '0;
      out_data_o.out_y   = '0;
      out_data_o.out_z   = '0;
      out_data_o.w_zero  = 1'b1;
      out_data_o.clipped = 1'b0;
    end else begin
      out_data_o.out_x   = quo[0];
      out_data_o.out_y   = quo[1];
      out_data_o.out_z   = quo[2];
      out_data_o.w_zero  = 1'b0;
      out_data_o.clipped = clip[0] | clip[1] | clip[2];
    end
  end

endmodule
